FILE: rtl/rgb_to_gray_nearest_downscaler_unit_assert.svh
// Assertion macros for the RGB to gray downscaler checker.
// Included by rgnd_checker; no other dependencies.
`ifndef RGB_TO_GRAY_NEAREST_DOWNSCALER_UNIT_ASSERT_SVH
`define RGB_TO_GRAY_NEAREST_DOWNSCALER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RGND_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RGND_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rgnd_pkg.sv
// Shared types and constants of the RGB to gray nearest-neighbor downscaler.
// No dependencies.
`default_nettype none

package rgnd_pkg;

    localparam int unsigned PIX_W           = 8;
    localparam int unsigned CFG_W           = 13;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned S_TDATA_W       = 3 * PIX_W;
    localparam int unsigned M_TDATA_W       = PIX_W;
    localparam int unsigned MAX_DIMENSION_DEF = 4096;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = CFG_W'(480);
    localparam logic [CFG_W-1:0] DST_WIDTH_RST  = CFG_W'(80);
    localparam logic [CFG_W-1:0] DST_HEIGHT_RST = CFG_W'(30);

    // gray = floor((30r + 59g + 11b) / 100), done as a multiply by
    // ceil(2^20 / 100) = 10486 folded into each weight, exact for sums < 43690
    localparam int unsigned GRAY_SHIFT = 20;
    localparam int unsigned GRAY_SUM_W = 28;
    localparam logic [GRAY_SUM_W-1:0] COEF_R = GRAY_SUM_W'(30 * 10486);
    localparam logic [GRAY_SUM_W-1:0] COEF_G = GRAY_SUM_W'(59 * 10486);
    localparam logic [GRAY_SUM_W-1:0] COEF_B = GRAY_SUM_W'(11 * 10486);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

FILE: rtl/rgb_to_gray_nearest_downscaler_unit.sv
// Path from input accept to result valid: input register, then result register.
// Throughput: one input item per cycle unless stalled; at most one result per item.
// Decimation decision is a running add and compare per axis in the second stage.
// Reset: synchronous, active low; clears pipeline valids and position counters,
// and loads the size registers with 640x480 -> 80x30.
`default_nettype none

module rgb_to_gray_nearest_downscaler_unit #(
    parameter int unsigned MAX_DIMENSION = rgnd_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_we,
    input  wire logic [rgnd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rgnd_pkg::CFG_W-1:0]      i_cfg_data,
    // input item
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [rgnd_pkg::S_TDATA_W-1:0]  i_s_tdata,   // red, green, blue
    // result item
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [rgnd_pkg::M_TDATA_W-1:0]       o_m_tdata,   // gray
    output logic                                 o_m_tlast,   // row_end
    output logic                                 o_m_tuser    // frame_end
);
    import rgnd_pkg::*;

    localparam int unsigned DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int unsigned PROD_W = 2 * DIM_W;
    localparam int unsigned CMP_W  = (CFG_W > DIM_W) ? CFG_W : DIM_W;

    logic [CFG_W-1:0]   r_src_width, r_src_height, r_dst_width, r_dst_height;

    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_s1_red, r_s1_green, r_s1_blue;

    logic [DIM_W-1:0]   r_src_col, n_src_col, r_src_row, n_src_row;
    logic [DIM_W-1:0]   r_out_col, n_out_col, r_out_row, n_out_row;
    logic [PROD_W-1:0]  r_col_tgt, n_col_tgt, r_col_base, n_col_base;
    logic [PROD_W-1:0]  r_row_tgt, n_row_tgt, r_row_base, n_row_base;

    logic               r_out_valid, n_out_valid;
    logic [PIX_W-1:0]   r_out_gray;
    logic               r_out_row_end, r_out_frame_end;

    logic [DIM_W-1:0]   sw, sh, dw, dh, dw_raw, dh_raw;
    logic               s1_adv;
    logic               col_sel, row_sel, emit, row_end, frame_end, last_col, last_row;
    logic [GRAY_SUM_W-1:0] gray_sum;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext == '0) begin
            return DIM_W'(1);
        end else if (ext > CMP_W'(MAX_DIMENSION)) begin
            return DIM_W'(MAX_DIMENSION);
        end
        return DIM_W'(ext);
    endfunction

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SRC_WIDTH_RST;
            r_src_height <= SRC_HEIGHT_RST;
            r_dst_width  <= DST_WIDTH_RST;
            r_dst_height <= DST_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                REG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                REG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        sw     = clamp_dim(r_src_width);
        sh     = clamp_dim(r_src_height);
        dw_raw = clamp_dim(r_dst_width);
        dh_raw = clamp_dim(r_dst_height);
        dw     = (dw_raw > sw) ? sw : dw_raw;
        dh     = (dh_raw > sh) ? sh : dh_raw;
    end

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_red   <= i_s_tdata[0*PIX_W +: PIX_W];
            r_s1_green <= i_s_tdata[1*PIX_W +: PIX_W];
            r_s1_blue  <= i_s_tdata[2*PIX_W +: PIX_W];
        end
    end

    assign gray_sum = GRAY_SUM_W'(r_s1_red)   * COEF_R
                    + GRAY_SUM_W'(r_s1_green) * COEF_G
                    + GRAY_SUM_W'(r_s1_blue)  * COEF_B;

    // selection and position update
    always_comb begin
        col_sel   = (r_out_col < dw) &&
                    ({1'b0, r_col_tgt} < ({1'b0, r_col_base} + (PROD_W+1)'(dw)));
        row_sel   = (r_out_row < dh) &&
                    ({1'b0, r_row_tgt} < ({1'b0, r_row_base} + (PROD_W+1)'(dh)));
        emit      = col_sel && row_sel;
        row_end   = emit && (({1'b0, r_out_col} + 1'b1) >= {1'b0, dw});
        frame_end = row_end && (({1'b0, r_out_row} + 1'b1) >= {1'b0, dh});
        last_col  = ({1'b0, r_src_col} + 1'b1) >= {1'b0, sw};
        last_row  = ({1'b0, r_src_row} + 1'b1) >= {1'b0, sh};

        n_src_col  = r_src_col;
        n_src_row  = r_src_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_col_tgt  = r_col_tgt;
        n_col_base = r_col_base;
        n_row_tgt  = r_row_tgt;
        n_row_base = r_row_base;

        if (s1_adv) begin
            if (last_col) begin
                n_src_col  = '0;
                n_out_col  = '0;
                n_col_tgt  = '0;
                n_col_base = '0;
                if (last_row) begin
                    n_src_row  = '0;
                    n_out_row  = '0;
                    n_row_tgt  = '0;
                    n_row_base = '0;
                end else begin
                    if (row_sel) begin
                        n_out_row = r_out_row + 1'b1;
                        n_row_tgt = r_row_tgt + PROD_W'(sh);
                    end
                    n_src_row  = r_src_row + 1'b1;
                    n_row_base = r_row_base + PROD_W'(dh);
                end
            end else begin
                if (col_sel) begin
                    n_out_col = r_out_col + 1'b1;
                    n_col_tgt = r_col_tgt + PROD_W'(sw);
                end
                n_src_col  = r_src_col + 1'b1;
                n_col_base = r_col_base + PROD_W'(dw);
            end
        end

        if (s1_adv) begin
            n_out_valid = emit;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_col_tgt   <= '0;
            r_col_base  <= '0;
            r_row_tgt   <= '0;
            r_row_base  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_src_col   <= n_src_col;
            r_src_row   <= n_src_row;
            r_out_col   <= n_out_col;
            r_out_row   <= n_out_row;
            r_col_tgt   <= n_col_tgt;
            r_col_base  <= n_col_base;
            r_row_tgt   <= n_row_tgt;
            r_row_base  <= n_row_base;
            r_out_valid <= n_out_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (s1_adv && emit) begin
            r_out_gray      <= gray_sum[GRAY_SHIFT +: PIX_W];
            r_out_row_end   <= row_end;
            r_out_frame_end <= frame_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_gray;
    assign o_m_tlast  = r_out_row_end;
    assign o_m_tuser  = r_out_frame_end;

endmodule

`default_nettype wire

FILE: rtl/rgnd_checker.sv
// Port-level checks of the RGB to gray downscaler, bound to the top level.
// Depends on rgnd_pkg and rgb_to_gray_nearest_downscaler_unit_assert.svh.
`default_nettype none
`include "rgb_to_gray_nearest_downscaler_unit_assert.svh"

module rgnd_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            o_s_tready,
    input  wire logic                            o_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic [rgnd_pkg::M_TDATA_W-1:0]  o_m_tdata,   // gray
    input  wire logic                            o_m_tlast,   // row_end
    input  wire logic                            o_m_tuser    // frame_end
);

    // hold a stalled result item
    `RGND_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser),
        "stalled result item changed")

    // frame end is always also a row end
    `RGND_ASSERT_NOW(a_frame_row, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tlast,
        "frame end without row end")

    // drop all results on reset
    `RGND_ASSERT_NOW(a_reset_clear, i_clk, i_rst_n, $past(!i_rst_n), !o_m_tvalid,
        "result valid right after reset")

    // a new result needs an item accepted earlier through the input register
    `RGND_ASSERT_NOW(a_out_source, i_clk, i_rst_n, $rose(o_m_tvalid),
        $past(i_s_tvalid && o_s_tready, 2), "result without accepted item")

endmodule

bind rgb_to_gray_nearest_downscaler_unit rgnd_checker u_rgnd_checker (.*);

`default_nettype wire

FILE: verif/tb_rgb_to_gray_nearest_downscaler_unit.sv
// Self-checking bench for rgb_to_gray_nearest_downscaler_unit: bursty pixel stream in,
// stalling result sink out, scoreboard against an in-bench gray/decimation predictor.
// Depends on rgnd_pkg and the unit RTL.
`default_nettype none

module tb_rgb_to_gray_nearest_downscaler_unit;
    import rgnd_pkg::*;

    localparam int unsigned MAX_DIM     = 4096;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          RAND_ITEMS  = 1100;

    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic             row_end;
        logic             frame_end;
    } gray_pix_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_SRC_WIDTH;
    logic [CFG_W-1:0]      i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tlast;
    logic                  o_m_tuser;

    rgb_to_gray_nearest_downscaler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    logic [S_TDATA_W-1:0] pixel_q [$];
    gray_pix_t            pending_gray_q [$];
    bit                   pix_taken      = 1'b0;
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;

    // predictor copy of the size registers and frame position
    logic [CFG_W-1:0] size_reg [4];
    logic [11:0]      src_col, src_row, out_col, out_row;
    logic [24:0]      col_target, col_base, row_target, row_base;

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned lim);
        int unsigned d;
        d = 32'(v);
        if (d == 0) d = 1;
        if (d > MAX_DIM) d = MAX_DIM;
        if (d > lim) d = lim;
        return d;
    endfunction

    task automatic clear_position();
        src_col    = '0;
        src_row    = '0;
        out_col    = '0;
        out_row    = '0;
        col_target = '0;
        col_base   = '0;
        row_target = '0;
        row_base   = '0;
    endtask

    task automatic downscale_step(input logic [S_TDATA_W-1:0] px);
        int unsigned sw, sh, dw, dh, gray;
        bit          col_sel, row_sel, emit, last_col, last_row;
        gray_pix_t   pix;
        sw   = clamp_size(size_reg[REG_SRC_WIDTH], MAX_DIM);
        sh   = clamp_size(size_reg[REG_SRC_HEIGHT], MAX_DIM);
        dw   = clamp_size(size_reg[REG_DST_WIDTH], sw);
        dh   = clamp_size(size_reg[REG_DST_HEIGHT], sh);
        gray = (30 * int'(px[7:0]) + 59 * int'(px[15:8]) + 11 * int'(px[23:16])) / 100;

        col_sel  = (out_col < dw) && (int'(col_target) < int'(col_base) + dw);
        row_sel  = (out_row < dh) && (int'(row_target) < int'(row_base) + dh);
        emit     = col_sel && row_sel;
        last_col = (int'(src_col) + 1) >= sw;
        last_row = (int'(src_row) + 1) >= sh;

        if (emit) begin
            pix.gray      = gray[PIX_W-1:0];
            pix.row_end   = (int'(out_col) + 1) >= dw;
            pix.frame_end = pix.row_end && ((int'(out_row) + 1) >= dh);
            pending_gray_q.push_back(pix);
        end

        if (col_sel) begin
            out_col    = out_col + 1'b1;
            col_target = col_target + 25'(sw);
        end
        src_col  = src_col + 1'b1;
        col_base = col_base + 25'(dw);

        if (last_col) begin
            src_col    = '0;
            out_col    = '0;
            col_target = '0;
            col_base   = '0;
            if (last_row) begin
                clear_position();
            end else begin
                if (row_sel) begin
                    out_row    = out_row + 1'b1;
                    row_target = row_target + 25'(sh);
                end
                src_row  = src_row + 1'b1;
                row_base = row_base + 25'(dh);
            end
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        gray_pix_t want;
        pix_taken = i_s_tvalid && o_s_tready;
        if (!i_rst_n) begin
            size_reg[REG_SRC_WIDTH]  = SRC_WIDTH_RST;
            size_reg[REG_SRC_HEIGHT] = SRC_HEIGHT_RST;
            size_reg[REG_DST_WIDTH]  = DST_WIDTH_RST;
            size_reg[REG_DST_HEIGHT] = DST_HEIGHT_RST;
            clear_position();
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_gray_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected item: gray %0d last %0b user %0b",
                                            o_m_tdata, o_m_tlast, o_m_tuser));
                end else begin
                    want = pending_gray_q.pop_front();
                    if (o_m_tdata !== want.gray || o_m_tlast !== want.row_end ||
                        o_m_tuser !== want.frame_end)
                        flag_mismatch($sformatf(
                            "mismatch: expected gray %0d last %0b user %0b, got %0d %0b %0b",
                            want.gray, want.row_end, want.frame_end,
                            o_m_tdata, o_m_tlast, o_m_tuser));
                end
            end
            if (i_cfg_we) size_reg[i_cfg_index] = i_cfg_data;
            if (pix_taken) downscale_step(i_s_tdata);
        end
    end

    // sender bursts and gaps, receiver stall pattern
    int          burst_left = 1;
    int          gap_left   = 0;
    int          pat_age    = 0;
    logic [15:0] ready_pat  = 16'hFFFF;

    always @(negedge i_clk) begin
        if (!i_s_tvalid || pix_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pixel_q.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end

        pat_age++;
        if (pat_age >= 97) begin
            pat_age = 0;
            case ($urandom_range(0, 3))
                0: ready_pat = 16'hFFFF;
                1: ready_pat = 16'($urandom) | 16'h0001;
                2: ready_pat = 16'($urandom & $urandom) | 16'h0001;
                default: ready_pat = 16'hFFFF << $urandom_range(1, 12);
            endcase
        end else begin
            ready_pat = {ready_pat[0], ready_pat[15:1]};
        end
        i_m_tready <= ready_pat[0];
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_rgb_to_gray_nearest_downscaler_unit: FAIL");
            $finish;
        end
    end

    task automatic load_sizes(input logic [CFG_W-1:0] sw, sh, dw, dh);
        logic [CFG_W-1:0] vals [4];
        vals[0] = sw;
        vals[1] = sh;
        vals[2] = dw;
        vals[3] = dh;
        for (int k = 0; k < 4; k++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data  <= vals[k];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_component();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_pixels(input int n);
        for (int k = 0; k < n; k++)
            pixel_q.push_back({pick_component(), pick_component(), pick_component()});
    endtask

    // hold until every item is taken and every result has arrived, then let the pipe settle
    task automatic drain();
        while (pixel_q.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (pending_gray_q.size() != 0) @(posedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_extreme_size();
        case ($urandom_range(0, 5))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'd4096;
            3: return 13'd4097;
            4: return 13'd8191;
            default: return 13'($urandom);
        endcase
    endfunction

    initial begin
        int sw, sh, dw, dh, n, rand_items;
        rand_items = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes, component extremes
        pixel_q.push_back(24'h000000);
        pixel_q.push_back(24'hFFFFFF);
        pixel_q.push_back(24'h0000FF);
        pixel_q.push_back(24'h00FF00);
        pixel_q.push_back(24'hFF0000);
        pixel_q.push_back(24'h808080);
        drain();

        // one-pixel frames
        load_sizes(13'd1, 13'd1, 13'd1, 13'd1);
        queue_pixels(3);
        drain();

        // zero sizes
        load_sizes(13'd0, 13'd0, 13'd0, 13'd0);
        queue_pixels(2);
        drain();

        // oversize, left mid-row for the next writes
        load_sizes(13'd8191, 13'd8191, 13'd8191, 13'd8191);
        queue_pixels(3);
        drain();
        load_sizes(13'd4097, 13'd4096, 13'd4096, 13'd4097);
        queue_pixels(2);
        drain();

        // upscale request, written mid-frame
        load_sizes(13'd3, 13'd2, 13'd7, 13'd9);
        queue_pixels(6);
        drain();

        while (rand_items < RAND_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                load_sizes(pick_extreme_size(), pick_extreme_size(),
                           pick_extreme_size(), pick_extreme_size());
                n = $urandom_range(10, 60);
            end else begin
                sw = $urandom_range(1, 16);
                sh = $urandom_range(1, 8);
                dw = ($urandom_range(0, 7) == 0) ? $urandom_range(1, sw + 4)
                                                 : $urandom_range(1, sw);
                case ($urandom_range(0, 2))
                    0: dh = (sh * dw) / (2 * sw);
                    1: dh = $urandom_range(1, sh);
                    default: dh = $urandom_range(1, sh + 3);
                endcase
                load_sizes(13'(sw), 13'(sh), 13'(dw), 13'(dh));
                n = sw * sh * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) n += $urandom_range(0, sw * sh - 1);
            end
            queue_pixels(n);
            rand_items += n;
            drain();
        end

        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && pending_gray_q.size() == 0) begin
            $display("tb_rgb_to_gray_nearest_downscaler_unit: PASS");
        end else begin
            $display("tb_rgb_to_gray_nearest_downscaler_unit: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: rgb_to_gray_nearest_downscaler_unit.f
+incdir+rtl
rtl/rgnd_pkg.sv
rtl/rgb_to_gray_nearest_downscaler_unit.sv
rtl/rgnd_checker.sv
verif/tb_rgb_to_gray_nearest_downscaler_unit.sv
